// ----- rtl/wavetable_voice_mixer_core_defines.svh -----
// Assertion macros shared by the voice mixer RTL.
`ifndef WAVETABLE_VOICE_MIXER_CORE_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_CORE_DEFINES_SVH

// Clocked check that is switched off while reset is held.
`define WVM_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WVM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/wvm_pkg.sv -----
package wvm_pkg;

    localparam int CMD_W    = 2;
    localparam int VOICE_W  = 2;
    localparam int FREQ_W   = 14;
    localparam int ADDR_W   = 13;
    localparam int SAMPLE_W = 8;
    localparam int LEN_W    = 14;
    localparam int PHASE_W  = 30;
    localparam int FRAC_W   = 16;
    localparam int INT_W    = PHASE_W - FRAC_W;
    localparam int INC_W    = 21;
    localparam int PWM_W    = 8;
    localparam int IN_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_FREQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SILENCE  = 2'd3;

    // Phase increment is (hz * 76087) >> 10, i.e. hz / 882 in 14.16.
    localparam logic [16:0]       INC_MUL   = 17'd76087;
    localparam int                INC_SHIFT = 10;
    localparam logic [PWM_W-1:0]  MID_LEVEL = 8'd128;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 14'd6924;

    localparam int DEF_VOICES      = 4;
    localparam int DEF_TABLE_DEPTH = 8192;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_phase_ctrl;

endpackage

// ----- rtl/wvm_ram.sv -----
module wvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/wvm_phase_unit.sv -----
module wvm_phase_unit
    import wvm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  t_phase_ctrl        i_ctrl,
    input  logic [FREQ_W-1:0]  i_freq,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [LEN_W-1:0]   i_table_length,
    output logic [AW-1:0]      o_index,
    output logic [PHASE_W-1:0] o_phase_next
);

    // The integer part is below 2^14 and the depth at least 2^8, so six
    // conditional subtractions bring it below the depth.
    function automatic logic [AW-1:0] reduce_index(input logic [INT_W-1:0] ip);
        logic [31:0] rem;
        logic [31:0] step;
        rem = 32'(ip);
        for (int k = 5; k >= 0; k--) begin
            step = 32'(TABLE_DEPTH) << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[AW-1:0];
    endfunction

    logic [INC_W-1:0]   r_inc;
    logic [PHASE_W:0]   r_padd;
    logic [FREQ_W+16:0] w_product;
    logic [PHASE_W-1:0] w_limit;
    logic [PHASE_W:0]   w_wrapped;

    assign w_product = 31'(i_freq) * 31'(INC_MUL);
    assign o_index   = reduce_index(i_phase[PHASE_W-1:FRAC_W]);
    assign w_limit   = {i_table_length, {FRAC_W{1'b0}}};

    always_comb begin
        if (r_padd >= (PHASE_W+1)'(w_limit)) begin
            w_wrapped = r_padd - (PHASE_W+1)'(w_limit);
        end else begin
            w_wrapped = r_padd;
        end
    end

    assign o_phase_next = w_wrapped[PHASE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_inc <= w_product[INC_SHIFT +: INC_W];
        end
        if (i_ctrl.add_en) begin
            r_padd <= (PHASE_W+1)'(i_phase) + (PHASE_W+1)'(r_inc);
        end
    end

endmodule

// ----- rtl/wavetable_voice_mixer_core.sv -----
// Wavetable voice mixer: frequency, table write and silence requests apply on acceptance.
// A tick request steps the voices one at a time through a shared phase unit and the
// table RAM, in the states READ, ACC and WRAP per voice, then divides and registers the
// level in DONE once the output register is free; the block takes no request until idle.
// Synchronous active-low reset clears phases, frequencies, the sequencer and the output
// valid, and sets table_length to 6924; the wavetable holds no reset value.
`include "wavetable_voice_mixer_core_defines.svh"

module wavetable_voice_mixer_core
    import wvm_pkg::*;
#(
    parameter int VOICES      = DEF_VOICES,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: table_length.
    input  logic                 i_cfg_we,
    input  logic [LEN_W-1:0]     i_cfg_data,
    // Request stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata from bit 0: voice[1:0], frequency_hz[15:2], table_address[28:16],
    // table_value[36:29], zero fill [39:37].
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser from bit 0: command[1:0].
    input  logic [CMD_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata from bit 0: pwm_level[7:0].
    output logic [PWM_W-1:0]     m_axis_tdata
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW  = $clog2(VOICES * 255 + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_WRAP = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // The sum is below 256*VOICES, so an eight-step restoring division by
    // the voice count gives the whole quotient.
    function automatic logic [PWM_W-1:0] div_voices(input logic [SW-1:0] s);
        logic [31:0] rem;
        logic [31:0] step;
        logic [PWM_W-1:0] q;
        rem = 32'(s);
        q   = '0;
        for (int k = PWM_W - 1; k >= 0; k--) begin
            step = 32'(VOICES) << k;
            if (rem >= step) begin
                rem  = rem - step;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Request fields.
    logic [CMD_W-1:0]    w_command;
    logic [VOICE_W-1:0]  w_voice;
    logic [FREQ_W-1:0]   w_freq_hz;
    logic [ADDR_W-1:0]   w_addr;
    logic [SAMPLE_W-1:0] w_value;

    assign w_command = s_axis_tuser;
    assign w_voice   = s_axis_tdata[1:0];
    assign w_freq_hz = s_axis_tdata[15:2];
    assign w_addr    = s_axis_tdata[28:16];
    assign w_value   = s_axis_tdata[36:29];

    logic [2:0]         r_state, n_state;
    logic [VIW-1:0]     r_voice;
    logic [SW-1:0]      r_sum;
    logic [LEN_W-1:0]   r_table_length;
    logic [PHASE_W-1:0] r_phase [VOICES];
    logic [FREQ_W-1:0]  r_freq  [VOICES];
    logic               r_out_valid;
    logic [PWM_W-1:0]   r_out_level;

    logic               w_accept;
    logic               w_tick_start;
    logic               w_last_voice;
    logic               w_out_free;
    logic [31:0]        w_voice_ext;
    logic [31:0]        w_addr_ext;
    logic               w_voice_ok;
    logic               w_addr_ok;
    logic               w_ram_we;
    logic [AW-1:0]      w_index;
    logic [PHASE_W-1:0] w_phase_next;
    logic [SAMPLE_W-1:0] w_sample;
    logic [PWM_W-1:0]   w_level;
    t_phase_ctrl        w_ctrl;
    logic [FREQ_W-1:0]  w_cur_freq;
    logic [PHASE_W-1:0] w_cur_phase;

    // Requests are taken only between ticks; the output register lets a new
    // request in while the last level still waits downstream.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_tick_start  = w_accept && (w_command == CMD_TICK);
    assign w_last_voice  = (r_voice == VIW'(VOICES - 1));
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_voice_ext = 32'(w_voice);
    assign w_addr_ext  = 32'(w_addr);
    assign w_voice_ok  = (w_voice_ext < 32'(VOICES));
    assign w_addr_ok   = (w_addr_ext < 32'(TABLE_DEPTH));
    assign w_ram_we    = w_accept && (w_command == CMD_WRITE) && w_addr_ok;

    assign w_cur_freq  = r_freq[r_voice];
    assign w_cur_phase = r_phase[r_voice];

    // The multiply runs while the table read is issued, the phase add while
    // the sample comes back, and the wrap result is written back in the WRAP state.
    assign w_ctrl.mul_en = (r_state == ST_READ);
    assign w_ctrl.add_en = (r_state == ST_ACC);

    wvm_phase_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_phase (
        .i_clk          (i_clk),
        .i_ctrl         (w_ctrl),
        .i_freq         (w_cur_freq),
        .i_phase        (w_cur_phase),
        .i_table_length (r_table_length),
        .o_index        (w_index),
        .o_phase_next   (w_phase_next)
    );

    wvm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr_ext[AW-1:0]),
        .i_wdata (w_value),
        .i_raddr (w_index),
        .o_rdata (w_sample)
    );

    // A sounding voice adds its sample offset by 128, a silent voice adds 128.
    assign w_level = (w_cur_freq == '0) ? MID_LEVEL : {~w_sample[SAMPLE_W-1], w_sample[6:0]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_tick_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_ACC;
            ST_ACC:  n_state = ST_WRAP;
            ST_WRAP: begin
                n_state = w_last_voice ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_voice        <= '0;
            r_table_length <= LENGTH_RESET;
            r_out_valid    <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
                r_freq[v]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_table_length <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_tick_start) begin
                r_voice <= '0;
            end
            if (w_accept && (w_command == CMD_SET_FREQ) && w_voice_ok) begin
                r_freq[w_voice_ext[VIW-1:0]] <= w_freq_hz;
            end
            if (w_accept && (w_command == CMD_SILENCE)) begin
                for (int v = 0; v < VOICES; v++) begin
                    r_freq[v] <= '0;
                end
            end
            if (r_state == ST_WRAP) begin
                if (w_cur_freq != '0) begin
                    r_phase[r_voice] <= w_phase_next;
                end
                if (!w_last_voice) begin
                    r_voice <= r_voice + VIW'(1);
                end
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload registers: running sum and the output level.
    always_ff @(posedge i_clk) begin
        if (w_tick_start) begin
            r_sum <= '0;
        end else if (r_state == ST_ACC) begin
            r_sum <= r_sum + SW'(w_level);
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_level <= div_voices(r_sum);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_level;

    // A finished tick always lands in a free output register.
    `WVM_ASSERT_CLK(a_done_out, (r_state == ST_DONE && !r_out_valid) |=> r_out_valid, "level lost")
    // An accepted tick starts the voice sweep at the first voice.
    `WVM_ASSERT_CLK(a_tick_go, w_tick_start |=> (r_state == ST_READ && r_voice == '0), "bad start")
    // Requests are never taken while a voice sweep is running.
    `WVM_ASSERT_CLK(a_busy_hold, (r_state != ST_IDLE) |-> !s_axis_tready, "request taken while busy")
    // The voice counter stays within the configured voice count.
    `WVM_ASSERT_CLK(a_voice_range, 32'(r_voice) < 32'(VOICES), "voice counter out of range")

endmodule

// ----- sim/wavetable_voice_mixer_core_test.sv -----
module wavetable_voice_mixer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wvm_pkg::*;

    // The block is built with four voices and a full 8192-entry wavetable.
    localparam int N_VOICES = 4;
    localparam int DEPTH    = 8192;

    // A tick request keeps the block busy through its voice sweep. Other requests
    // return nothing, so before a register write or at the end of the run the bench
    // waits SETTLE_CYCLES after the last level has come back.
    localparam int TICK_CYCLES   = 3 * N_VOICES + 2;
    localparam int SETTLE_CYCLES = 2 * TICK_CYCLES;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Frequencies used by the tick-heavy phases, close to the top of the 14-bit field,
    // so that every voice moves on to a new table entry at each tick.
    localparam int HIGH_FREQ_LOW  = 15500;
    localparam int HIGH_FREQ_HIGH = 16383;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [LEN_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata from bit 0: voice[1:0], frequency_hz[15:2], table_address[28:16],
    // table_value[36:29], zero fill [39:37].
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    // tuser from bit 0: command[1:0].
    logic [CMD_W-1:0]     s_axis_tuser  = CMD_TICK;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    // tdata from bit 0: pwm_level[7:0].
    logic [PWM_W-1:0]     m_axis_tdata;

    wavetable_voice_mixer_core #(
        .VOICES      (N_VOICES),
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mirror of the block's state. It is advanced when a request is issued, which is
    // safe because requests are accepted and answered strictly in order.
    logic [PHASE_W-1:0]  phase_model  [N_VOICES];
    logic [FREQ_W-1:0]   freq_model   [N_VOICES];
    logic [SAMPLE_W-1:0] wave_model   [DEPTH];
    bit                  wave_loaded  [DEPTH];
    logic [LEN_W-1:0]    length_model;

    // Levels that the block still owes, oldest first.
    logic [PWM_W-1:0]    pending_levels [$];
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;
    int unsigned         sent_count     = 0;
    bit                  idle_en        = 1'b1;

    // Directed requests. Rows with a typed level are ones whose answer is obvious:
    // the silent mix after reset, the mix of three voices sitting on the most negative
    // sample, and the silent mix after a silence request. Every other tick is checked
    // against the predictor.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VOICE_W-1:0]  voice;
        logic [FREQ_W-1:0]   freq;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        logic [PWM_W-1:0]    level;
    } t_directed_row;

    t_directed_row directed_rows [19] = '{
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b1, 8'd128},
        '{CMD_WRITE,    2'd0, 14'd0,     13'd0,    8'h80, 1'b0, 8'd0},
        '{CMD_WRITE,    2'd0, 14'd0,     13'd8191, 8'h7F, 1'b0, 8'd0},
        '{CMD_WRITE,    2'd0, 14'd0,     13'd1,    8'h00, 1'b0, 8'd0},
        '{CMD_SET_FREQ, 2'd0, 14'd11025, 13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_SET_FREQ, 2'd1, 14'd1,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_SET_FREQ, 2'd2, 14'd16383, 13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_SET_FREQ, 2'd3, 14'd0,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b1, 8'd32},
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_SET_FREQ, 2'd3, 14'd882,   13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_SILENCE,  2'd3, 14'd16383, 13'd8191, 8'hFF, 1'b0, 8'd0},
        '{CMD_TICK,     2'd3, 14'd16383, 13'd8191, 8'hFF, 1'b1, 8'd128},
        '{CMD_SET_FREQ, 2'd0, 14'd1,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b0, 8'd0},
        '{CMD_SET_FREQ, 2'd1, 14'd11025, 13'd4096, 8'h55, 1'b0, 8'd0},
        '{CMD_TICK,     2'd0, 14'd0,     13'd0,    8'h00, 1'b0, 8'd0}
    };

    // One tick of the mixer: every sounding voice looks up its sample, shifted from
    // signed to offset binary, and then steps its phase; silent voices add mid level.
    function automatic logic [PWM_W-1:0] mix_voices();
        logic [9:0]          sum;
        logic [31:0]         limit;
        logic [31:0]         next_phase;
        logic [INT_W-1:0]    slot;
        logic [SAMPLE_W-1:0] sample;
        sum   = '0;
        limit = 32'(length_model) << FRAC_W;
        for (int v = 0; v < N_VOICES; v++) begin
            if (freq_model[v] == '0) begin
                sum = sum + 10'(MID_LEVEL);
            end else begin
                slot       = phase_model[v][PHASE_W-1:FRAC_W];
                sample     = wave_model[ADDR_W'(slot % DEPTH)];
                sum        = sum + {2'b00, ~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]};
                next_phase = 32'(phase_model[v])
                           + ((32'(freq_model[v]) * 32'(INC_MUL)) >> INC_SHIFT);
                // A single subtraction only; with a zero length this subtracts nothing
                // and the phase is simply cut back to its 30 bits.
                if (next_phase >= limit) begin
                    next_phase = next_phase - limit;
                end
                phase_model[v] = next_phase[PHASE_W-1:0];
            end
        end
        return PWM_W'(sum / 10'(N_VOICES));
    endfunction

    task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [VOICE_W-1:0] voice,
                                 input logic [FREQ_W-1:0] freq, input logic [ADDR_W-1:0] addr,
                                 input logic [SAMPLE_W-1:0] value, output bit produces,
                                 output logic [PWM_W-1:0] level);
        produces = 1'b0;
        level    = '0;
        case (cmd)
            CMD_TICK: begin
                level    = mix_voices();
                produces = 1'b1;
            end
            CMD_SET_FREQ: begin
                if (int'(voice) < N_VOICES) begin
                    freq_model[voice] = freq;
                end
            end
            CMD_WRITE: begin
                if (int'(addr) < DEPTH) begin
                    wave_model[addr]  = value;
                    wave_loaded[addr] = 1'b1;
                end
            end
            default: begin
                for (int v = 0; v < N_VOICES; v++) begin
                    freq_model[v] = '0;
                end
            end
        endcase
    endtask

    // Presents one request and returns at the edge where it was taken. The valid is
    // left high, so back-to-back requests need no second assignment in one step.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VOICE_W-1:0] voice,
                                input logic [FREQ_W-1:0] freq, input logic [ADDR_W-1:0] addr,
                                input logic [SAMPLE_W-1:0] value, input logic typed,
                                input logic [PWM_W-1:0] typed_level);
        bit              produces;
        logic [PWM_W-1:0] level;
        int              gap;
        apply_request(cmd, voice, freq, addr, value, produces, level);
        if (idle_en && $urandom_range(99) < 20) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, value, addr, freq, voice};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        if (produces) begin
            pending_levels.push_back(typed ? typed_level : level);
        end
    endtask

    // Issues a request. Ahead of a tick, any table entry that a sounding voice is about
    // to read and that was never loaded gets a random sample first.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VOICE_W-1:0] voice,
                         input logic [FREQ_W-1:0] freq, input logic [ADDR_W-1:0] addr,
                         input logic [SAMPLE_W-1:0] value, input logic typed,
                         input logic [PWM_W-1:0] typed_level);
        logic [INT_W-1:0]  slot;
        logic [ADDR_W-1:0] entry;
        if (cmd == CMD_TICK) begin
            for (int v = 0; v < N_VOICES; v++) begin
                slot  = phase_model[v][PHASE_W-1:FRAC_W];
                entry = ADDR_W'(slot % DEPTH);
                if (freq_model[v] != '0 && !wave_loaded[entry]) begin
                    send_request(CMD_WRITE, VOICE_W'($urandom), FREQ_W'($urandom), entry,
                                 SAMPLE_W'($urandom), 1'b0, '0);
                end
            end
        end
        send_request(cmd, voice, freq, addr, value, typed, typed_level);
    endtask

    // Random request. Tick-heavy traffic keeps every voice sounding at a high pitch;
    // mixed traffic retunes, reloads and silences voices between ticks.
    task automatic issue_random(input bit heavy);
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [FREQ_W-1:0] freq;
        pick = $urandom_range(99);
        if (heavy) begin
            cmd  = (pick < 95) ? CMD_TICK : (pick < 99) ? CMD_SET_FREQ : CMD_WRITE;
            freq = FREQ_W'($urandom_range(HIGH_FREQ_LOW, HIGH_FREQ_HIGH));
        end else begin
            cmd = (pick < 40) ? CMD_TICK : (pick < 68) ? CMD_SET_FREQ :
                  (pick < 94) ? CMD_WRITE : CMD_SILENCE;
            case ($urandom_range(3))
                0:       freq = '0;
                1:       freq = FREQ_W'($urandom_range(1, 200));
                2:       freq = FREQ_W'($urandom_range(0, 11025));
                default: freq = FREQ_W'($urandom_range(0, 16383));
            endcase
        end
        issue(cmd, VOICE_W'($urandom), freq, ADDR_W'($urandom), SAMPLE_W'($urandom),
              1'b0, '0);
    endtask

    // Waits until every owed level has come back and the block has had time to finish
    // any request that answers nothing.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A phase sends about the given number of requests, table loads included.
    task automatic run_phase(input logic [LEN_W-1:0] length, input int unsigned items,
                             input bit heavy, input bit idle);
        int unsigned phase_end;
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= length;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        length_model = length;
        idle_en      = idle;
        phase_end    = sent_count + items;
        // A tick-heavy phase starts by tuning all voices high, so that they keep
        // stepping through the table for the whole phase.
        if (heavy) begin
            for (int v = 0; v < N_VOICES; v++) begin
                issue(CMD_SET_FREQ, VOICE_W'(v),
                      FREQ_W'($urandom_range(HIGH_FREQ_LOW, HIGH_FREQ_HIGH)),
                      ADDR_W'($urandom), SAMPLE_W'($urandom), 1'b0, '0);
            end
        end
        while (sent_count < phase_end) issue_random(heavy);
    endtask

    // Result side: every accepted level is compared with the oldest one owed. The
    // ready is dropped in random bursts while idling is allowed.
    initial begin
        logic [PWM_W-1:0] expected_level;
        int               stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_levels.size() == 0) begin
                    $display("%0t: pwm_level with no request owed, expected none, got %0d",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    expected_level = pending_levels.pop_front();
                    if (m_axis_tdata !== expected_level) begin
                        $display("%0t: pwm_level mismatch, expected %0d, got %0d",
                                 $time, expected_level, m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    m_axis_tready <= 1'b1;
                end
            end else if (idle_en && $urandom_range(99) < 15) begin
                stall_left    = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[wavetable_voice_mixer_core] ERROR");
        $finish;
    end

    initial begin
        length_model = LENGTH_RESET;
        for (int v = 0; v < N_VOICES; v++) begin
            phase_model[v] = '0;
            freq_model[v]  = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests run at the reset table length.
        foreach (directed_rows[i]) begin
            issue(directed_rows[i].cmd, directed_rows[i].voice, directed_rows[i].freq,
                  directed_rows[i].addr, directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].level);
        end

        // The shortest nonzero and a full-table length first. Then the widest length followed by
        // zero, both with tick-heavy runs at high pitch, so that the single wrap
        // subtraction and the wrap-free zero length both get exercised. The last phase
        // uses a random length and runs without any idling on either side.
        run_phase(LEN_W'(1), 70, 1'b0, 1'b1);
        run_phase(LEN_W'(DEPTH), 70, 1'b0, 1'b1);
        run_phase(LEN_W'(16383), 330, 1'b1, 1'b1);
        run_phase(LEN_W'(0), 240, 1'b1, 1'b1);
        run_phase(LEN_W'($urandom_range(1, 16383)), 110, 1'b0, 1'b0);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("[wavetable_voice_mixer_core] OK");
        end else begin
            $display("[wavetable_voice_mixer_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- wavetable_voice_mixer_core.f -----
+incdir+rtl
rtl/wvm_pkg.sv
rtl/wvm_ram.sv
rtl/wvm_phase_unit.sv
rtl/wavetable_voice_mixer_core.sv
sim/wavetable_voice_mixer_core_test.sv
